FILE: hw/rtl/krt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table package
// Shared widths, codes and payload types of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;
    localparam int TableDepth = 16;
    localparam int IdxW  = $clog2(TableDepth);
    localparam int CntW  = $clog2(TableDepth + 1);
    localparam int SumW  = 16 + CntW;
    localparam int KeyW  = 16;
    localparam int ScW   = 16;
    localparam int RecW  = KeyW + ScW;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    localparam logic signed [ScW-1:0] ScoreTop = 16'sd32767;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [KeyW-1:0]         key;
        logic signed [ScW-1:0]   score_in;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [ScW-1:0]   match_score;
        logic [4:0]              entry_count;
        logic signed [ScW-1:0]   average_score;
        logic [14:0]             max_score;
        logic signed [ScW-1:0]   min_score;
    } t_rsp;
endpackage

FILE: hw/rtl/krt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table channels
// Valid/ready channels carrying a request or a result.
// ----------------------------------------------------------------------------
interface krt_req_if;
    import krt_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface krt_rsp_if;
    import krt_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/krt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/krt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module krt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [krt_pkg::SumW-1:0] i_num,
    input  logic [krt_pkg::CntW-1:0]        i_den,
    output logic                            o_done,
    output logic signed [krt_pkg::ScW-1:0]  o_quot
);
    import krt_pkg::*;
    localparam int StepW = $clog2(SumW + 1);

    logic [SumW-1:0]  r_q;
    logic [CntW:0]    r_rem;
    logic [CntW-1:0]  r_den;
    logic             r_neg;
    logic             r_busy;
    logic [StepW-1:0] r_step;
    logic [CntW:0]    n_rem;
    logic [SumW-1:0]  v_quot;

    always_comb begin
        n_rem = {r_rem[CntW-1:0], r_q[SumW-1]};
        v_quot = r_neg ? (~r_q + 1'b1) : r_q;
    end
    assign o_quot = v_quot[ScW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= StepW'(SumW);
                r_q    <= i_num[SumW-1] ? (~i_num + 1'b1) : i_num;
                r_neg  <= i_num[SumW-1];
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_rem >= {1'b0, r_den}) begin
                    r_rem <= n_rem - {1'b0, r_den};
                    r_q   <= {r_q[SumW-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[SumW-2:0], 1'b0};
                end
                r_step <= r_step - 1'b1;
                if (r_step == StepW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: hw/rtl/keyed_record_table_with_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyed record table with statistics
// Ordered key/score table with insert, lookup and remove, plus statistics.
// ----------------------------------------------------------------------------
// Usage: requests arrive on i_req (opcode, key, score_in) and each request
// yields exactly one result on o_rsp. Both are valid/ready channels; a
// transfer happens on a clock edge where valid and ready are both high.
// The records live in one synchronous RAM holding key and score together.
// A request runs as a sequence: a scan reads entries one per cycle in order
// to find the first matching key; a remove then shifts the later records
// down one place, reading each entry and then writing it one place lower;
// a final scan reads every held entry to form the maximum and minimum,
// while a serial divider works out the average, one quotient bit a cycle.
// A request waits for both the final scan and the division to finish before
// its result is loaded; on an empty table the scans are skipped and the
// division is not waited for.
// One request is processed at a time and the next is taken in the cycle
// after the result is loaded, even while that result still waits to be read.
// Reset (synchronous, active low) empties the table; RAM contents need no
// clearing since only entries below the count are read. A stalled receiver
// holds the result in its register; a finished request then waits for it.
// ----------------------------------------------------------------------------
module keyed_record_table_with_stats (
    input  logic i_clk,
    input  logic i_rst_n,
    krt_req_if.sink   i_req,
    krt_rsp_if.source o_rsp
);
    import krt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_SHIFT, S_STAT, S_WAIT, S_OUT
    } t_state;

    t_state                r_state;
    t_req                  r_req;
    logic [CntW-1:0]       r_count;
    logic signed [SumW-1:0] r_sum;
    logic [CntW-1:0]       r_ptr;      // entry whose data the RAM returns when r_rd_ok
    logic                  r_rd_ok;    // RAM output corresponds to r_ptr
    logic [1:0]            r_status;
    logic signed [ScW-1:0] r_match;
    logic signed [ScW-1:0] r_hi;
    logic signed [ScW-1:0] r_lo;
    logic                  r_div_done;
    logic                  r_out_valid;
    t_rsp                  r_out;

    logic                  w_we;
    logic [IdxW-1:0]       w_waddr;
    logic [RecW-1:0]       w_wdata;
    logic [IdxW-1:0]       w_raddr;
    logic [RecW-1:0]       w_rdata;
    logic [CntW-1:0]       w_next;
    logic                  w_div_start;
    logic                  w_div_done;
    logic signed [ScW-1:0] w_quot;
    logic signed [ScW-1:0] w_rd_score;
    logic [KeyW-1:0]       w_rd_key;
    logic                  w_take;
    logic                  w_out_load;

    assign w_rd_key   = w_rdata[RecW-1:ScW];
    assign w_rd_score = w_rdata[ScW-1:0];
    assign w_take     = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // The result register is loaded once it is empty or being read this cycle.
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || o_rsp.ready);

    krt_ram #(.Width(RecW), .Depth(TableDepth)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    krt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (r_sum),
        .i_den  (r_count),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_next = r_ptr + 1'b1;

    // Write port: insert at idle, shift moves entry r_ptr down to r_ptr-1.
    // Reads present r_ptr while the RAM output is not yet valid, then run ahead.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_count[IdxW-1:0];
        w_wdata = {i_req.payload.key, i_req.payload.score_in};
        w_raddr = '0;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_we = w_take && (i_req.payload.opcode == OP_INSERT)
                       && (r_count < CntW'(TableDepth));
            end
            S_FIND: begin
                w_raddr = r_rd_ok ? w_next[IdxW-1:0] : r_ptr[IdxW-1:0];
            end
            S_STAT: begin
                w_raddr = r_rd_ok ? w_next[IdxW-1:0] : r_ptr[IdxW-1:0];
                // The divider starts on the first statistics cycle, after sum
                // and count have settled.
                w_div_start = !r_rd_ok;
            end
            S_SHIFT: begin
                w_we    = r_rd_ok;
                w_waddr = IdxW'(r_ptr - 1'b1);
                w_wdata = w_rdata;
                w_raddr = r_rd_ok ? w_next[IdxW-1:0] : r_ptr[IdxW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_ptr       <= '0;
            r_div_done  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take) begin
                r_div_done <= 1'b0;
            end else if (w_div_done) begin
                r_div_done <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_req    <= i_req.payload;
                        r_status <= ST_DONE;
                        r_match  <= '0;
                        r_ptr    <= '0;
                        r_rd_ok  <= 1'b0;
                        if (i_req.payload.opcode == OP_INSERT) begin
                            if (r_count < CntW'(TableDepth)) begin
                                r_count <= r_count + 1'b1;
                                r_sum   <= r_sum + SumW'(i_req.payload.score_in);
                            end else begin
                                r_status <= ST_FULL;
                            end
                            r_state <= S_STAT;
                        end else if (i_req.payload.opcode == OP_LOOKUP ||
                                     i_req.payload.opcode == OP_REMOVE) begin
                            r_state <= S_FIND;
                        end else begin
                            r_state <= S_STAT;
                        end
                        r_hi <= '0;
                        r_lo <= ScoreTop;
                    end
                end
                S_FIND: begin
                    // The first cycle presents entry 0; its data arrives next cycle.
                    if (!r_rd_ok) begin
                        if (r_count == '0) begin
                            r_status <= ST_MISSING;
                            r_ptr    <= '0;
                            r_state  <= S_STAT;
                        end else begin
                            r_rd_ok <= 1'b1;
                        end
                    end else if (w_rd_key == r_req.key) begin
                        if (r_req.opcode == OP_LOOKUP) begin
                            r_match <= w_rd_score;
                            r_ptr   <= '0;
                            r_rd_ok <= 1'b0;
                            r_state <= S_STAT;
                        end else begin
                            r_sum   <= r_sum - SumW'(w_rd_score);
                            r_ptr   <= w_next;
                            r_rd_ok <= 1'b0;
                            r_state <= S_SHIFT;
                        end
                    end else if (w_next >= r_count) begin
                        r_status <= ST_MISSING;
                        r_ptr    <= '0;
                        r_rd_ok  <= 1'b0;
                        r_state  <= S_STAT;
                    end else begin
                        r_ptr <= w_next;
                    end
                end
                S_SHIFT: begin
                    // r_ptr is the entry being moved down; data valid next cycle.
                    if (!r_rd_ok) begin
                        if (r_ptr >= r_count) begin
                            r_count <= r_count - 1'b1;
                            r_ptr   <= '0;
                            r_state <= S_STAT;
                        end else begin
                            r_rd_ok <= 1'b1;
                        end
                    end else begin
                        r_rd_ok <= 1'b0;
                        r_ptr   <= w_next;
                    end
                end
                S_STAT: begin
                    if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                        if (r_count == '0) begin
                            r_state <= S_WAIT;
                        end
                    end else begin
                        if (w_rd_score > r_hi) r_hi <= w_rd_score;
                        if (w_rd_score < r_lo) r_lo <= w_rd_score;
                        r_ptr <= w_next;
                        if (w_next >= r_count) begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    r_rd_ok <= 1'b0;
                    if (r_count == '0 || r_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out.status        <= r_status;
                        r_out.match_score   <= r_match;
                        r_out.entry_count   <= 5'(r_count);
                        r_out.average_score <= (r_count == '0) ? '0 : w_quot;
                        r_out.max_score     <= r_hi[14:0];
                        r_out.min_score     <= r_lo;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(TableDepth))
        else $error("record count beyond table depth");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> (r_state == S_IDLE))
        else $error("request taken while busy");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> r_out_valid)
        else $error("result not presented");
`endif
endmodule
